[design/kt_pkg.sv]
package kt_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int CFG_W     = 31;
    localparam int RAM_DEPTH = 64;
    localparam int RAM_AW    = 6;
    localparam int PC_W      = 8;

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] COV_INIT = WORD_W'(100) << FRAC_BITS;

    localparam logic [CFG_W-1:0] DT_RESET = CFG_W'(6554);
    localparam logic [CFG_W-1:0] Q_RESET  = CFG_W'(6554);
    localparam logic [CFG_W-1:0] R_RESET  = CFG_W'(655360);

    // register indexes on the config channel
    localparam logic [1:0] REG_STEP  = 2'd0;
    localparam logic [1:0] REG_QNOIS = 2'd1;
    localparam logic [1:0] REG_RNOIS = 2'd2;

    // entries 0..19 hold the filter state (x then P row-major), the rest are scratch
    localparam logic [RAM_AW-1:0] A_Y0   = 6'd20;
    localparam logic [RAM_AW-1:0] A_Y1   = 6'd21;
    localparam logic [RAM_AW-1:0] A_S00  = 6'd22;
    localparam logic [RAM_AW-1:0] A_S11  = 6'd23;
    localparam logic [RAM_AW-1:0] A_TMP  = 6'd24;
    localparam logic [RAM_AW-1:0] A_INV  = 6'd25;
    localparam logic [RAM_AW-1:0] A_SI   = 6'd26;
    localparam logic [RAM_AW-1:0] A_K    = 6'd32;
    localparam logic [RAM_AW-1:0] A_T    = 6'd40;
    localparam logic [RAM_AW-1:0] A_STATE_END = 6'd20;

    // operand sources beyond the RAM
    localparam logic [6:0] SRC_DT  = 7'd64;
    localparam logic [6:0] SRC_Q   = 7'd65;
    localparam logic [6:0] SRC_R   = 7'd66;
    localparam logic [6:0] SRC_MX  = 7'd67;
    localparam logic [6:0] SRC_MY  = 7'd68;
    localparam logic [6:0] SRC_ACC = 7'd69;

    localparam logic [PC_W-1:0] PC_END = 8'd163;

    typedef enum logic [3:0] {
        OP_NOP, OP_MUL, OP_MADD, OP_ADD, OP_ADDA, OP_SUB, OP_SUBA,
        OP_ASUB, OP_MOV, OP_NEG, OP_DIV, OP_BRZ, OP_END
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_MULT, ST_COMB, ST_DIV, ST_OUT
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [6:0]        a;
        logic [6:0]        b;
        logic              wr;
        logic [RAM_AW-1:0] dst;
    } instr_t;

    function automatic logic [WORD_W-1:0] sat_add(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        return s[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] sat_sub(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        return s[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] sat_neg(logic [WORD_W-1:0] a);
        return (a == WORD_MIN) ? WORD_MAX : (~a + WORD_W'(1));
    endfunction

    function automatic logic [WORD_W-1:0] cov_reset(logic [RAM_AW-1:0] addr);
        if (addr == 6'd4 || addr == 6'd9 || addr == 6'd14 || addr == 6'd19)
            return COV_INIT;
        return '0;
    endfunction

    function automatic logic [RAM_AW-1:0] p_at(logic [1:0] i, logic [1:0] j);
        return 6'd4 + {2'b00, i, j};
    endfunction

    function automatic logic [RAM_AW-1:0] k_at(logic [1:0] i, logic j);
        return A_K + {3'b000, i, j};
    endfunction

    function automatic logic [RAM_AW-1:0] si_at(logic k, logic j);
        return A_SI + {4'b0000, k, j};
    endfunction

    function automatic logic [RAM_AW-1:0] t_at(logic i, logic [1:0] j);
        return A_T + {3'b000, i, j};
    endfunction

    function automatic logic [6:0] m(logic [RAM_AW-1:0] addr);
        return {1'b0, addr};
    endfunction

    function automatic instr_t mk(op_t op, logic [6:0] a, logic [6:0] b, logic wr,
                                  logic [RAM_AW-1:0] dst);
        instr_t r;
        r.op  = op;
        r.a   = a;
        r.b   = b;
        r.wr  = wr;
        r.dst = dst;
        return r;
    endfunction

    // microprogram: predict, then innovation, gain and correction
    function automatic instr_t prog(logic [PC_W-1:0] pc);
        instr_t          r;
        logic [PC_W-1:0] n;
        logic [1:0]      i;
        logic [1:0]      j;
        r = mk(OP_NOP, 7'd0, 7'd0, 1'b0, 6'd0);
        n = '0;
        i = '0;
        j = '0;
        if (pc < 8'd4) begin
            unique case (pc[1:0])
                2'd0: r = mk(OP_MUL,  SRC_DT, m(6'd2), 1'b0, 6'd0);
                2'd1: r = mk(OP_ADDA, m(6'd0), 7'd0,   1'b1, 6'd0);
                2'd2: r = mk(OP_MUL,  SRC_DT, m(6'd3), 1'b0, 6'd0);
                2'd3: r = mk(OP_ADDA, m(6'd1), 7'd0,   1'b1, 6'd1);
            endcase
        end else if (pc < 8'd20) begin
            // rows 0,1 += dt * rows 2,3
            n = pc - 8'd4;
            j = n[3:2];
            unique case (n[1:0])
                2'd0: r = mk(OP_MUL,  SRC_DT, m(p_at(2'd2, j)), 1'b0, 6'd0);
                2'd1: r = mk(OP_ADDA, m(p_at(2'd0, j)), 7'd0, 1'b1, p_at(2'd0, j));
                2'd2: r = mk(OP_MUL,  SRC_DT, m(p_at(2'd3, j)), 1'b0, 6'd0);
                2'd3: r = mk(OP_ADDA, m(p_at(2'd1, j)), 7'd0, 1'b1, p_at(2'd1, j));
            endcase
        end else if (pc < 8'd36) begin
            // cols 0,1 += dt * cols 2,3
            n = pc - 8'd20;
            i = n[3:2];
            unique case (n[1:0])
                2'd0: r = mk(OP_MUL,  SRC_DT, m(p_at(i, 2'd2)), 1'b0, 6'd0);
                2'd1: r = mk(OP_ADDA, m(p_at(i, 2'd0)), 7'd0, 1'b1, p_at(i, 2'd0));
                2'd2: r = mk(OP_MUL,  SRC_DT, m(p_at(i, 2'd3)), 1'b0, 6'd0);
                2'd3: r = mk(OP_ADDA, m(p_at(i, 2'd1)), 7'd0, 1'b1, p_at(i, 2'd1));
            endcase
        end else if (pc < 8'd44) begin
            n = pc - 8'd36;
            i = n[2:1];
            if (!n[0])
                r = mk(OP_MOV, m(p_at(i, i)), 7'd0, 1'b0, 6'd0);
            else
                r = mk(OP_ADDA, SRC_Q, 7'd0, 1'b1, p_at(i, i));
        end else if (pc < 8'd59) begin
            unique case (pc)
                8'd44: r = mk(OP_SUB,  SRC_MX, m(6'd0), 1'b1, A_Y0);
                8'd45: r = mk(OP_SUB,  SRC_MY, m(6'd1), 1'b1, A_Y1);
                8'd46: r = mk(OP_ADD,  m(p_at(2'd0, 2'd0)), SRC_R, 1'b1, A_S00);
                8'd47: r = mk(OP_ADD,  m(p_at(2'd1, 2'd1)), SRC_R, 1'b1, A_S11);
                8'd48: r = mk(OP_MUL,  m(p_at(2'd0, 2'd1)), m(p_at(2'd1, 2'd0)), 1'b1, A_TMP);
                8'd49: r = mk(OP_MUL,  m(A_S00), m(A_S11), 1'b0, 6'd0);
                8'd50: r = mk(OP_ASUB, m(A_TMP), 7'd0, 1'b0, 6'd0);
                8'd51: r = mk(OP_BRZ,  7'd0, 7'd0, 1'b0, 6'd0);
                8'd52: r = mk(OP_DIV,  7'd0, 7'd0, 1'b1, A_INV);
                8'd53: r = mk(OP_MUL,  m(A_S11), m(A_INV), 1'b1, si_at(1'b0, 1'b0));
                8'd54: r = mk(OP_NEG,  m(p_at(2'd0, 2'd1)), 7'd0, 1'b0, 6'd0);
                8'd55: r = mk(OP_MUL,  SRC_ACC, m(A_INV), 1'b1, si_at(1'b0, 1'b1));
                8'd56: r = mk(OP_NEG,  m(p_at(2'd1, 2'd0)), 7'd0, 1'b0, 6'd0);
                8'd57: r = mk(OP_MUL,  SRC_ACC, m(A_INV), 1'b1, si_at(1'b1, 1'b0));
                8'd58: r = mk(OP_MUL,  m(A_S00), m(A_INV), 1'b1, si_at(1'b1, 1'b1));
                default: r = mk(OP_NOP, 7'd0, 7'd0, 1'b0, 6'd0);
            endcase
        end else if (pc < 8'd75) begin
            // gain K = P[:,0:1] * Sinv
            n = pc - 8'd59;
            i = n[3:2];
            if (!n[0])
                r = mk(OP_MUL, m(p_at(i, 2'd0)), m(si_at(1'b0, n[1])), 1'b0, 6'd0);
            else
                r = mk(OP_MADD, m(p_at(i, 2'd1)), m(si_at(1'b1, n[1])), 1'b1, k_at(i, n[1]));
        end else if (pc < 8'd91) begin
            n = pc - 8'd75;
            i = n[3:2];
            unique case (n[1:0])
                2'd0: r = mk(OP_MUL,  m(k_at(i, 1'b0)), m(A_Y0), 1'b0, 6'd0);
                2'd1: r = mk(OP_MADD, m(k_at(i, 1'b1)), m(A_Y1), 1'b0, 6'd0);
                2'd2: r = mk(OP_ADDA, m({4'b0000, i}), 7'd0, 1'b1, {4'b0000, i});
                2'd3: r = mk(OP_NOP,  7'd0, 7'd0, 1'b0, 6'd0);
            endcase
        end else if (pc < 8'd155) begin
            // P -= K * P[0:1,:]; rows 0,1 go to scratch first
            n = pc - 8'd91;
            i = n[5:4];
            j = n[3:2];
            unique case (n[1:0])
                2'd0: r = mk(OP_MUL,  m(k_at(i, 1'b0)), m(p_at(2'd0, j)), 1'b0, 6'd0);
                2'd1: r = mk(OP_MADD, m(k_at(i, 1'b1)), m(p_at(2'd1, j)), 1'b0, 6'd0);
                2'd2: r = mk(OP_SUBA, m(p_at(i, j)), 7'd0, 1'b1,
                             i[1] ? p_at(i, j) : t_at(i[0], j));
                2'd3: r = mk(OP_NOP,  7'd0, 7'd0, 1'b0, 6'd0);
            endcase
        end else if (pc < PC_END) begin
            n = pc - 8'd155;
            i = {1'b0, n[2]};
            j = n[1:0];
            r = mk(OP_MOV, m(t_at(n[2], j)), 7'd0, 1'b1, p_at(i, j));
        end else begin
            r = mk(OP_END, 7'd0, 7'd0, 1'b0, 6'd0);
        end
        return r;
    endfunction

endpackage

[design/kt_ram.sv]
module kt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[design/kt_div.sv]
module kt_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         den,
    input  logic                neg,
    output logic                done,
    output logic [31:0]         quot
);

    import kt_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [32:0] quo_reg;
    logic [31:0] den_reg;
    logic        neg_reg;

    logic [32:0] rem_sh;
    logic        fits;
    logic [32:0] lim;
    logic [32:0] mag;

    // numerator is 2^(2*FRAC_BITS): a single one bit on the first step
    assign rem_sh = {rem_reg, (cnt_reg == 6'd32)};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            den_reg <= den;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            quo_reg <= {quo_reg[31:0], fits};
        end
    end

    assign lim  = neg_reg ? {1'b0, WORD_MIN} : {1'b0, WORD_MAX};
    assign mag  = (quo_reg > lim) ? lim : quo_reg;
    assign quot = neg_reg ? (~mag[31:0] + 32'd1) : mag[31:0];
    assign done = done_reg;

endmodule

[design/kt_alu.sv]
module kt_alu (
    input  logic               clk,
    input  logic               mul_en,
    input  kt_pkg::op_t        op,
    input  logic [31:0]        opa,
    input  logic [31:0]        opb,
    input  logic [31:0]        acc,
    output logic [31:0]        res
);

    import kt_pkg::*;

    logic [63:0] prod_reg;
    logic        neg_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;

    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [47:0] pmag;
    logic [47:0] plim;
    logic [47:0] pclip;
    logic [31:0] pval;

    assign mag_a = opa[31] ? (~opa + 32'd1) : opa;
    assign mag_b = opb[31] ? (~opb + 32'd1) : opb;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= 64'(mag_a) * 64'(mag_b);
            neg_reg  <= opa[31] ^ opb[31];
            a_reg    <= opa;
            b_reg    <= opb;
        end
    end

    // scale by 2^-FRAC_BITS toward zero, then saturate
    assign pmag  = prod_reg[63:FRAC_BITS];
    assign plim  = neg_reg ? 48'(WORD_MIN) : 48'(WORD_MAX);
    assign pclip = (pmag > plim) ? plim : pmag;
    assign pval  = neg_reg ? (~pclip[31:0] + 32'd1) : pclip[31:0];

    always_comb
    begin
        unique case (op)
            OP_MUL:  res = pval;
            OP_MADD: res = sat_add(acc, pval);
            OP_ADD:  res = sat_add(a_reg, b_reg);
            OP_ADDA: res = sat_add(acc, a_reg);
            OP_SUB:  res = sat_sub(a_reg, b_reg);
            OP_SUBA: res = sat_sub(a_reg, acc);
            OP_ASUB: res = sat_sub(acc, a_reg);
            OP_MOV:  res = a_reg;
            OP_NEG:  res = sat_neg(a_reg);
            default: res = acc;
        endcase
    end

endmodule

[design/kalman_tracker_cv_2d.sv]
// channel  | dir | beat contents
// ---------+-----+-------------------------------------------------------------
// s_axis   | in  | tdata[63:0]: meas_x [31:0], meas_y [63:32]
// m_axis   | out | tdata[127:0]: est_x, est_y, est_vx, est_vy; tuser: update_skipped
// cfg      | in  | cfg_index 0 step_interval, 1 process_noise, 2 measurement_noise
//
// A measurement runs the microprogram of 164 steps: 141 of them pass through
// RAM read, multiply, and combine and write back; the 20 no-op steps and the
// zero test stop after the multiply stage; the end step adds the result load;
// and the reciprocal step waits on the bit-serial divider. A singular
// innovation jumps straight to the end step. All steps share the single
// read-modify-write datapath on the state RAM. Reset is immediate: the state
// entries carry valid bits and read as their reset value until first written.
// The result sits in an output register, so a stalled m_tready only holds the
// engine at its end step while the previous result is still waiting; a new
// beat is taken as soon as the result has been loaded.
module kalman_tracker_cv_2d (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,    // meas_x [31:0], meas_y [63:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,    // est_x, est_y, est_vx, est_vy, low to high
    output logic         m_tuser,    // update_skipped
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data
);

    import kt_pkg::*;

    state_t            state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              skip_reg, skip_next;
    logic [31:0]       acc_reg;
    logic [CFG_W-1:0]  dt_reg, q_reg, r_reg;
    logic [31:0]       mx_reg, my_reg;
    logic [19:0]       valid_reg;
    logic [31:0]       xs_reg [4];
    logic [RAM_AW-1:0] rda_reg, rdb_reg;
    logic              m_tvalid_reg;
    logic [127:0]      out_data_reg;
    logic              out_skip_reg;

    instr_t            instr;
    logic [31:0]       rdata_a, rdata_b;
    logic [31:0]       ram_a, ram_b;
    logic [31:0]       opa, opb;
    logic [31:0]       alu_res;
    logic [31:0]       div_q;
    logic              div_done;
    logic              div_start;
    logic              mul_en;
    logic              ram_we;
    logic [31:0]       ram_wdata;
    logic              out_load;
    logic              in_accept;
    logic              acc_load;

    assign instr     = prog(pc_reg);
    assign in_accept = s_tvalid && s_tready;

    kt_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (instr.dst),
        .wdata   (ram_wdata),
        .raddr_a (instr.a[RAM_AW-1:0]),
        .rdata_a (rdata_a),
        .raddr_b (instr.b[RAM_AW-1:0]),
        .rdata_b (rdata_b)
    );

    kt_alu u_alu (
        .clk    (clk),
        .mul_en (mul_en),
        .op     (instr.op),
        .opa    (opa),
        .opb    (opb),
        .acc    (acc_reg),
        .res    (alu_res)
    );

    kt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (acc_reg[31] ? (~acc_reg + 32'd1) : acc_reg),
        .neg   (acc_reg[31]),
        .done  (div_done),
        .quot  (div_q)
    );

    // state entries never written since reset read as their reset value
    assign ram_a = (rda_reg < A_STATE_END && !valid_reg[rda_reg[4:0]])
                   ? cov_reset(rda_reg) : rdata_a;
    assign ram_b = (rdb_reg < A_STATE_END && !valid_reg[rdb_reg[4:0]])
                   ? cov_reset(rdb_reg) : rdata_b;

    always_comb
    begin
        opa = ram_a;
        if (instr.a[6])
        begin
            unique case (instr.a)
                SRC_DT:  opa = {1'b0, dt_reg};
                SRC_Q:   opa = {1'b0, q_reg};
                SRC_R:   opa = {1'b0, r_reg};
                SRC_MX:  opa = mx_reg;
                SRC_MY:  opa = my_reg;
                SRC_ACC: opa = acc_reg;
                default: opa = '0;
            endcase
        end
    end

    always_comb
    begin
        opb = ram_b;
        if (instr.b[6])
        begin
            unique case (instr.b)
                SRC_DT:  opb = {1'b0, dt_reg};
                SRC_Q:   opb = {1'b0, q_reg};
                SRC_R:   opb = {1'b0, r_reg};
                SRC_MX:  opb = mx_reg;
                SRC_MY:  opb = my_reg;
                SRC_ACC: opb = acc_reg;
                default: opb = '0;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_FETCH;
            ST_FETCH: state_next = ST_MULT;
            ST_MULT:
            begin
                priority case (instr.op)
                    OP_NOP, OP_BRZ: state_next = ST_FETCH;
                    OP_END:         state_next = ST_OUT;
                    OP_DIV:         state_next = ST_DIV;
                    default:        state_next = ST_COMB;
                endcase
            end
            ST_COMB:  state_next = ST_FETCH;
            ST_DIV:   if (div_done) state_next = ST_FETCH;
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        mul_en    = (state_reg == ST_MULT);
        div_start = (state_reg == ST_MULT) && (instr.op == OP_DIV);
        acc_load  = (state_reg == ST_COMB) || (state_reg == ST_DIV && div_done);
        ram_we    = acc_load && instr.wr;
        ram_wdata = (state_reg == ST_DIV) ? div_q : alu_res;
        out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    end

    always_comb
    begin
        pc_next   = pc_reg;
        skip_next = skip_reg;
        if (in_accept)
        begin
            pc_next   = '0;
            skip_next = 1'b0;
        end
        else if (state_reg == ST_MULT && instr.op == OP_BRZ && acc_reg == 32'd0)
        begin
            // singular innovation: keep the prediction
            pc_next   = PC_END;
            skip_next = 1'b1;
        end
        else if ((state_reg == ST_MULT && (instr.op == OP_NOP || instr.op == OP_BRZ))
                 || acc_load)
        begin
            pc_next = pc_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pc_reg       <= '0;
            skip_reg     <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            dt_reg       <= DT_RESET;
            q_reg        <= Q_RESET;
            r_reg        <= R_RESET;
            for (int k = 0; k < 4; k++)
                xs_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            skip_reg  <= skip_next;
            if (ram_we && instr.dst < A_STATE_END)
                valid_reg[instr.dst[4:0]] <= 1'b1;
            // shadow copy of the estimate for the result beat
            if (ram_we && instr.dst < 6'd4)
                xs_reg[instr.dst[1:0]] <= ram_wdata;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_STEP)
                    dt_reg <= cfg_data;
                else if (cfg_index == REG_QNOIS)
                    q_reg <= cfg_data;
                else if (cfg_index == REG_RNOIS)
                    r_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mx_reg <= s_tdata[31:0];
            my_reg <= s_tdata[63:32];
        end
        if (state_reg == ST_FETCH)
        begin
            rda_reg <= instr.a[RAM_AW-1:0];
            rdb_reg <= instr.b[RAM_AW-1:0];
        end
        if (acc_load)
            acc_reg <= ram_wdata;
        if (out_load)
        begin
            out_data_reg <= {xs_reg[3], xs_reg[2], xs_reg[1], xs_reg[0]};
            out_skip_reg <= skip_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_skip_reg;

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_COMB || state_reg == ST_DIV))
        else $error("state RAM written outside a write-back step");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (acc_reg != 32'd0))
        else $error("reciprocal started on a zero determinant");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (pc_reg <= PC_END))
        else $error("program counter past the end of the program");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while still held");

    a_skip_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !skip_reg)
        else $error("divider running on a skipped update");

endmodule
